>>> rtl/adc_pkg.sv
// Shared types, codes and defaults for the adaptive decimating capture block.
package adc_pkg;

  localparam int unsigned RowsDefault  = 512;
  localparam int unsigned WavesDefault = 4;
  localparam int unsigned WordW        = 16;
  localparam int unsigned PeriodW      = 4;
  localparam int unsigned FillOutW     = 10;
  localparam int unsigned RowInW       = 9;
  localparam int unsigned ActW         = 2;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 4;
  localparam int unsigned PortWords    = 4;

  localparam logic [PeriodW-1:0] FinalPeriodReset = 4'd6;
  localparam logic [PeriodW-1:0] PeriodMax        = 4'd15;
  localparam logic [PeriodW-1:0] PeriodStart      = 4'd1;

  // Item action codes
  typedef enum logic [ActW-1:0] {
    ActTick  = 2'd0,
    ActStart = 2'd1,
    ActStop  = 2'd2,
    ActRead  = 2'd3
  } action_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCaptureEnable = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFinalPeriod   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic compact_step;
    logic load_result;
  } adc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic compact_start;
    logic sweep_done;
  } adc_status_t;

endpackage

>>> rtl/adc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module adc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/adc_ctrl.sv
// Controller state machine: item acceptance, sequencing and result hand-off.
module adc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  adc_pkg::adc_status_t status_i,
  output adc_pkg::adc_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StExec    = 4'b0010,
    StCompact = 4'b0100,
    StFinish  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.compact_start ? StCompact : StFinish;
      end
      StCompact: begin
        cmd_o.compact_step = 1'b1;
        if (status_i.sweep_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/adc_dpath.sv
// Datapath: capture state, sample buffer, compaction sweep and result register.
module adc_dpath #(
  parameter int unsigned ROWS  = adc_pkg::RowsDefault,
  parameter int unsigned WAVES = adc_pkg::WavesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  adc_pkg::adc_cmd_t             cmd_i,
  output adc_pkg::adc_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [adc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [adc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [adc_pkg::ActW-1:0]      action_i,
  input  logic [adc_pkg::RowInW-1:0]    read_row_i,
  input  logic [adc_pkg::WordW-1:0]     sample_i [adc_pkg::PortWords],
  output logic                          running_o,
  output logic [adc_pkg::FillOutW-1:0]  fill_count_o,
  output logic [adc_pkg::PeriodW-1:0]   current_period_o,
  output logic                          stored_o,
  output logic                          compacted_o,
  output logic                          finished_o,
  output logic [adc_pkg::WordW-1:0]     row_word_o [adc_pkg::PortWords]
);

  localparam int unsigned AW = $clog2(ROWS);
  localparam int unsigned FW = $clog2(ROWS + 1);
  localparam int unsigned XW = FW + adc_pkg::RowInW;
  localparam int unsigned DW = WAVES * adc_pkg::WordW;
  localparam int unsigned PW = adc_pkg::PeriodW;
  localparam int unsigned WW = adc_pkg::WordW;

  localparam logic [FW-1:0] RowsF = FW'(ROWS);
  localparam logic [XW-1:0] RowsX = XW'(ROWS);

  // Configuration registers
  logic          cap_en_q;
  logic [PW-1:0] final_q;

  // Captured item
  adc_pkg::action_e             act_q;
  logic [adc_pkg::RowInW-1:0]   row_q;
  logic [WW-1:0]                samp_q [WAVES];

  // Capture state
  logic [FW-1:0] fill_q, fill_d;
  logic [PW-1:0] phase_q, phase_d;
  logic [PW-1:0] period_q, period_d;
  logic          active_q, active_d;

  // Per-item flags
  logic stored_q, stored_d;
  logic compacted_q, compacted_d;
  logic finished_q, finished_d;
  logic row_ok_q, row_ok_d;

  // Compaction sweep
  logic [FW-1:0] src_q, src_d;
  logic [FW-1:0] gs_q, gs_d;
  logic [FW-1:0] dst_q, dst_d;
  logic [PW-1:0] n_q, n_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;

  // Buffer ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata, row_wdata;

  // Tick decode
  logic [PW-1:0] phase_next, period_inc;
  logic [FW-1:0] fill_plus;
  logic          hit, do_store, full, stop_cond;
  logic [XW-1:0] group_end, row_x, fill_x;
  logic          group_ok, sweep_go;

  assign phase_next = phase_q + PW'(1);
  assign period_inc = period_q + PW'(1);
  assign fill_plus  = fill_q + FW'(1);
  assign hit        = (phase_next == period_q);
  assign do_store   = cmd_i.exec && (act_q == adc_pkg::ActTick) && hit && cap_en_q &&
                      active_q && (fill_q < RowsF);
  assign full       = (fill_plus == RowsF);
  assign stop_cond  = (period_q == final_q) || (period_q == adc_pkg::PeriodMax);
  assign row_x      = XW'(row_q);
  assign fill_x     = XW'(fill_q);
  assign group_end  = XW'(gs_q) + XW'(period_q);
  assign group_ok   = (group_end <= RowsX);
  assign sweep_go   = cmd_i.compact_step && group_ok;

  assign status_o.compact_start = do_store && full && !stop_cond && (period_inc >= PW'(2));
  assign status_o.sweep_done    = !group_ok;

  // Pack the stored row from the active wave words
  always_comb begin
    row_wdata = '0;
    for (int k = 0; k < WAVES; k++) begin
      row_wdata[k*WW +: WW] = samp_q[k];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_en_q <= 1'b1;
      final_q  <= adc_pkg::FinalPeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        adc_pkg::CfgCaptureEnable: cap_en_q <= cfg_wdata_i[0];
        adc_pkg::CfgFinalPeriod:   final_q  <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= adc_pkg::action_e'(action_i);
      row_q <= read_row_i;
      for (int k = 0; k < WAVES; k++) begin
        samp_q[k] <= sample_i[k];
      end
    end
  end

  // Execute the item and step the sweep
  always_comb begin
    fill_d      = fill_q;
    phase_d     = phase_q;
    period_d    = period_q;
    active_d    = active_q;
    stored_d    = stored_q;
    compacted_d = compacted_q;
    finished_d  = finished_q;
    row_ok_d    = row_ok_q;
    src_d       = src_q;
    gs_d        = gs_q;
    dst_d       = dst_q;
    n_d         = n_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;

    if (cmd_i.exec) begin
      stored_d    = 1'b0;
      compacted_d = 1'b0;
      finished_d  = 1'b0;
      row_ok_d    = (row_x < fill_x) && (row_x < RowsX);
      case (act_q)
        adc_pkg::ActTick: begin
          phase_d = hit ? '0 : phase_next;
          if (do_store) begin
            stored_d = 1'b1;
            fill_d   = fill_plus;
            if (full) begin
              if (stop_cond) begin
                active_d   = 1'b0;
                finished_d = 1'b1;
              end else begin
                period_d    = period_inc;
                compacted_d = 1'b1;
                src_d       = '0;
                gs_d        = '0;
                dst_d       = '0;
                n_d         = '0;
              end
            end
          end
        end
        adc_pkg::ActStart: begin
          active_d = 1'b1;
          fill_d   = '0;
          period_d = adc_pkg::PeriodStart;
          phase_d  = '0;
        end
        adc_pkg::ActStop: begin
          active_d = 1'b0;
        end
        default: ;
      endcase
    end

    // Walk full groups: drop each group's first row, move the rest down
    if (cmd_i.compact_step) begin
      if (group_ok) begin
        wr_pend_d = (n_q != '0);
        wr_addr_d = dst_q[AW-1:0];
        if (n_q != '0) begin
          dst_d = dst_q + FW'(1);
        end
        if (n_q == period_q - PW'(1)) begin
          n_d  = '0;
          gs_d = group_end[FW-1:0];
        end else begin
          n_d = n_q + PW'(1);
        end
        src_d = src_q + FW'(1);
      end else begin
        fill_d = dst_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      phase_q   <= '0;
      period_q  <= '0;
      active_q  <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      phase_q   <= phase_d;
      period_q  <= period_d;
      active_q  <= active_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stored_q    <= stored_d;
    compacted_q <= compacted_d;
    finished_q  <= finished_d;
    row_ok_q    <= row_ok_d;
    src_q       <= src_d;
    gs_q        <= gs_d;
    dst_q       <= dst_d;
    n_q         <= n_d;
    wr_addr_q   <= wr_addr_d;
  end

  // Buffer port selection: sweep write-back has the write port outside execute
  assign ram_we    = do_store || wr_pend_q;
  assign ram_waddr = wr_pend_q ? wr_addr_q : fill_q[AW-1:0];
  assign ram_wdata = wr_pend_q ? ram_rdata : row_wdata;
  assign ram_re    = (cmd_i.exec && (act_q == adc_pkg::ActRead)) || sweep_go;
  assign ram_raddr = cmd_i.compact_step ? src_q[AW-1:0] : row_x[AW-1:0];

  adc_ram #(
    .WIDTH (DW),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      running_o        <= active_q;
      fill_count_o     <= adc_pkg::FillOutW'(fill_q);
      current_period_o <= period_q;
      stored_o         <= stored_q;
      compacted_o      <= compacted_q;
      finished_o       <= finished_q;
      for (int k = 0; k < adc_pkg::PortWords; k++) begin
        row_word_o[k] <= '0;
      end
      if ((act_q == adc_pkg::ActRead) && row_ok_q) begin
        for (int k = 0; k < WAVES; k++) begin
          row_word_o[k] <= ram_rdata[k*WW +: WW];
        end
      end
    end
  end

endmodule

>>> rtl/adaptive_decimating_capture.sv
// Top level of the adaptive decimating capture block.
// Each accepted item is captured, executed in the execute state and its result loaded in the
// finish state once the output register is free. A tick that fills the buffer at neither the
// final nor the maximum period adds a compaction sweep: one buffer row per cycle through the
// RAM read port, written back behind it. One item is in flight at a time; one result may wait.
// Reset clears control state and configuration; buffer contents stay undefined, no clear pass.
module adaptive_decimating_capture #(
  parameter int unsigned ROWS  = adc_pkg::RowsDefault,
  parameter int unsigned WAVES = adc_pkg::WavesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [adc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [adc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [adc_pkg::ActW-1:0]      action_i,
  input  logic [adc_pkg::RowInW-1:0]    read_row_i,
  input  logic [adc_pkg::WordW-1:0]     sample_0_i,
  input  logic [adc_pkg::WordW-1:0]     sample_1_i,
  input  logic [adc_pkg::WordW-1:0]     sample_2_i,
  input  logic [adc_pkg::WordW-1:0]     sample_3_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          running_o,
  output logic [adc_pkg::FillOutW-1:0]  fill_count_o,
  output logic [adc_pkg::PeriodW-1:0]   current_period_o,
  output logic                          stored_o,
  output logic                          compacted_o,
  output logic                          finished_o,
  output logic [adc_pkg::WordW-1:0]     row_word_0_o,
  output logic [adc_pkg::WordW-1:0]     row_word_1_o,
  output logic [adc_pkg::WordW-1:0]     row_word_2_o,
  output logic [adc_pkg::WordW-1:0]     row_word_3_o
);

  adc_pkg::adc_cmd_t    cmd;
  adc_pkg::adc_status_t status;
  logic [adc_pkg::WordW-1:0] sample [adc_pkg::PortWords];
  logic [adc_pkg::WordW-1:0] row_word [adc_pkg::PortWords];

  assign sample[0] = sample_0_i;
  assign sample[1] = sample_1_i;
  assign sample[2] = sample_2_i;
  assign sample[3] = sample_3_i;

  assign row_word_0_o = row_word[0];
  assign row_word_1_o = row_word[1];
  assign row_word_2_o = row_word[2];
  assign row_word_3_o = row_word[3];

  adc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  adc_dpath #(
    .ROWS  (ROWS),
    .WAVES (WAVES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .read_row_i       (read_row_i),
    .sample_i         (sample),
    .running_o        (running_o),
    .fill_count_o     (fill_count_o),
    .current_period_o (current_period_o),
    .stored_o         (stored_o),
    .compacted_o      (compacted_o),
    .finished_o       (finished_o),
    .row_word_o       (row_word)
  );

endmodule

>>> rtl/adc_checker.sv
// Port-level checks for the adaptive decimating capture block, bound to the top level.
module adc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          running_o,
  input logic                          stored_o,
  input logic                          compacted_o,
  input logic                          finished_o,
  input logic [adc_pkg::FillOutW-1:0]  fill_count_o,
  input logic [adc_pkg::WordW-1:0]     row_word_0_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fill_count_o) && $stable(row_word_0_o))
    else $error("stalled result changed");

  // One item at a time: busy right after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // A finishing tick stored its row, stopped capture and did not compact
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> stored_o && !running_o && !compacted_o)
    else $error("inconsistent finish flags");

endmodule

bind adaptive_decimating_capture adc_checker u_adc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .running_o    (running_o),
  .stored_o     (stored_o),
  .compacted_o  (compacted_o),
  .finished_o   (finished_o),
  .fill_count_o (fill_count_o),
  .row_word_0_o (row_word_0_o)
);

>>> sim/tb_top.sv
// Self-checking testbench for the adaptive decimating capture block.
module tb_top;
  import adc_pkg::*;

  localparam int unsigned Rows       = RowsDefault;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned PrintLimit = 40;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    action_e                         act;
    logic [RowInW-1:0]               row;
    logic [PortWords-1:0][WordW-1:0] samples;
  } capture_item_t;

  typedef struct packed {
    logic                            running;
    logic [FillOutW-1:0]             fill;
    logic [PeriodW-1:0]              period;
    logic                            stored;
    logic                            compacted;
    logic                            finished;
    logic [PortWords-1:0][WordW-1:0] words;
  } capture_status_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CfgCaptureEnable;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  action_e             act = ActTick;
  logic [RowInW-1:0]   read_row = '0;
  logic [WordW-1:0]    sample_0 = '0;
  logic [WordW-1:0]    sample_1 = '0;
  logic [WordW-1:0]    sample_2 = '0;
  logic [WordW-1:0]    sample_3 = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                running;
  logic [FillOutW-1:0] fill_count;
  logic [PeriodW-1:0]  current_period;
  logic                stored;
  logic                compacted;
  logic                finished;
  logic [WordW-1:0]    row_word_0;
  logic [WordW-1:0]    row_word_1;
  logic [WordW-1:0]    row_word_2;
  logic [WordW-1:0]    row_word_3;

  // Shadow copy of the capture state
  logic [PortWords*WordW-1:0] shadow_rows [Rows];
  int unsigned                fill_q = 0;
  logic [PeriodW-1:0]         phase_q = '0;
  logic [PeriodW-1:0]         period_q = '0;
  logic                       active_q = 1'b0;
  logic                       enable_q = 1'b1;
  logic [PeriodW-1:0]         stop_period_q = FinalPeriodReset;

  capture_status_t expected_status_q [$];
  int unsigned     mismatch_count = 0;
  int unsigned     results_seen = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     hold_left = 0;
  int unsigned     sender_gap_pct = 0;
  int unsigned     receiver_stall_pct = 0;

  adaptive_decimating_capture i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (act),
    .read_row_i       (read_row),
    .sample_0_i       (sample_0),
    .sample_1_i       (sample_1),
    .sample_2_i       (sample_2),
    .sample_3_i       (sample_3),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .running_o        (running),
    .fill_count_o     (fill_count),
    .current_period_o (current_period),
    .stored_o         (stored),
    .compacted_o      (compacted),
    .finished_o       (finished),
    .row_word_0_o     (row_word_0),
    .row_word_1_o     (row_word_1),
    .row_word_2_o     (row_word_2),
    .row_word_3_o     (row_word_3)
  );

  always #1 clk = ~clk;

  // Drop the first row of every full group of s rows, discard the partial tail
  function automatic void decimate_rows(int unsigned s);
    int unsigned dst;
    dst = 0;
    for (int unsigned g = 0; g < Rows / s; g++) begin
      for (int unsigned n = 0; n + 1 < s; n++) begin
        shadow_rows[dst] = shadow_rows[g * s + 1 + n];
        dst++;
      end
    end
    fill_q = dst;
  endfunction

  // Advance the shadow state by one item and return the status it should give
  function automatic capture_status_t predict_capture(capture_item_t it);
    capture_status_t st;
    st = '0;
    case (it.act)
      ActTick: begin
        phase_q = phase_q + 1'b1;
        if (phase_q == period_q) begin
          phase_q = '0;
          if (enable_q && active_q && fill_q < Rows) begin
            shadow_rows[fill_q] = it.samples;
            fill_q++;
            st.stored = 1'b1;
            if (fill_q == Rows) begin
              if (period_q == stop_period_q || period_q >= PeriodMax) begin
                active_q    = 1'b0;
                st.finished = 1'b1;
              end else begin
                period_q     = period_q + 1'b1;
                st.compacted = 1'b1;
                if (period_q >= 2) decimate_rows(period_q);
              end
            end
          end
        end
      end
      ActStart: begin
        active_q = 1'b1;
        fill_q   = 0;
        period_q = PeriodStart;
        phase_q  = '0;
      end
      ActStop: begin
        active_q = 1'b0;
      end
      default: begin
        if (it.row < fill_q) st.words = shadow_rows[it.row];
      end
    endcase
    st.running = active_q;
    st.fill    = fill_q[FillOutW-1:0];
    st.period  = period_q;
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    // keep the log short when the block is badly broken
    if (mismatch_count <= PrintLimit) $display("error: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] want,
                             input logic [WordW-1:0] got);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: expected %h, got %h",
                                results_seen, name, want, got));
  endtask

  // Check each accepted status against the oldest prediction, then pick the next stall
  always @(posedge clk) begin : check_results
    capture_status_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = expected_status_q.pop_front();
        check_field("running", want.running, running);
        check_field("fill_count", want.fill, fill_count);
        check_field("current_period", want.period, current_period);
        check_field("stored", want.stored, stored);
        check_field("compacted", want.compacted, compacted);
        check_field("finished", want.finished, finished);
        check_field("row_word_0", want.words[0], row_word_0);
        check_field("row_word_1", want.words[1], row_word_1);
        check_field("row_word_2", want.words[2], row_word_2);
        check_field("row_word_3", want.words[3], row_word_3);
      end
      results_seen++;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // End the run when neither side moves an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    sender_gap_pct     = (mode == IdleSender) ? 87 : (mode == IdleBoth) ? 37 : 0;
    receiver_stall_pct = (mode == IdleReceiver) ? 87 : (mode == IdleBoth) ? 37 : 0;
  endtask

  function automatic capture_item_t make_item(input action_e a, input logic [RowInW-1:0] row,
                                              input logic [PortWords*WordW-1:0] samples);
    capture_item_t it;
    it.act     = a;
    it.row     = row;
    it.samples = samples;
    return it;
  endfunction

  function automatic logic [PortWords*WordW-1:0] random_samples();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Mostly rows that hold data, sometimes the fill point or anywhere
  function automatic logic [RowInW-1:0] pick_row();
    case ($urandom_range(5))
      0:       return RowInW'($urandom_range(Rows - 1));
      1:       return RowInW'(fill_q);
      default: return (fill_q != 0) ? RowInW'($urandom_range(fill_q - 1))
                                    : RowInW'($urandom_range(Rows - 1));
    endcase
  endfunction

  function automatic capture_item_t tick_item();
    return make_item(ActTick, RowInW'($urandom_range(Rows - 1)), random_samples());
  endfunction

  function automatic capture_item_t read_item();
    return make_item(ActRead, pick_row(), random_samples());
  endfunction

  // Offer one item, hold it until accepted, then record its prediction
  task automatic offer_item(input capture_item_t it);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    act      <= it.act;
    read_row <= it.row;
    sample_0 <= it.samples[0];
    sample_1 <= it.samples[1];
    sample_2 <= it.samples[2];
    sample_3 <= it.samples[3];
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_status_q.push_back(predict_capture(it));
  endtask

  // Stop offering and wait until every predicted status has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CfgCaptureEnable) enable_q = value[0];
    else stop_period_q = value[PeriodW-1:0];
  endtask

  // Field extremes, every action, reads around the fill point, restart
  task automatic test_directed();
    settle();
    set_idling(IdleNone);
    offer_item(make_item(ActRead, 9'd0, '0));
    offer_item(make_item(ActRead, 9'd511, '1));
    repeat (3) offer_item(make_item(ActTick, 9'd511, '1));
    offer_item(make_item(ActStop, 9'd0, '0));
    offer_item(make_item(ActStart, 9'd511, '1));
    offer_item(make_item(ActTick, 9'd0, '0));
    offer_item(make_item(ActTick, 9'd0, '1));
    offer_item(make_item(ActTick, 9'd0, {PortWords{16'hAAAA}}));
    offer_item(make_item(ActTick, 9'd0, {PortWords{16'h5555}}));
    for (int r = 0; r < 5; r++) offer_item(make_item(ActRead, RowInW'(r), '0));
    offer_item(make_item(ActRead, 9'd511, '0));
    offer_item(make_item(ActStop, 9'd0, '0));
    offer_item(make_item(ActTick, 9'd0, 64'h0123_4567_89AB_CDEF));
    offer_item(make_item(ActRead, 9'd3, '0));
    offer_item(make_item(ActStart, 9'd0, '0));
    offer_item(make_item(ActRead, 9'd0, '0));
    offer_item(make_item(ActTick, 9'd0, 64'hFEDC_BA98_7654_3210));
    offer_item(make_item(ActRead, 9'd0, '0));
  endtask

  // Ticks with capture disabled advance nothing visible; re-enable and store
  task automatic test_enable_gating();
    settle();
    write_reg(CfgCaptureEnable, CfgDataW'(0));
    set_idling(IdleBoth);
    offer_item(make_item(ActStart, 9'd0, '0));
    repeat (6) offer_item(tick_item());
    offer_item(make_item(ActRead, 9'd0, '0));
    settle();
    write_reg(CfgCaptureEnable, CfgDataW'(1));
    repeat (4) offer_item(tick_item());
    repeat (4) offer_item(read_item());
  endtask

  // Hold the receiver off for a long stretch while items keep coming
  task automatic test_backpressure();
    settle();
    set_idling(IdleNone);
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    offer_item(make_item(ActStart, 9'd0, '0));
    repeat (40) begin
      if ($urandom_range(3) == 0) offer_item(read_item());
      else offer_item(tick_item());
    end
  endtask

  // Capture from start until the buffer fills at the stop period, optionally
  // lowering the stop period below the running one so the maximum period ends it
  task automatic test_fill_to_finish(input logic [PeriodW-1:0] first_stop,
                                     input logic [PeriodW-1:0] swap_at,
                                     input logic [PeriodW-1:0] later_stop);
    int unsigned n;
    bit          swapped;
    settle();
    write_reg(CfgCaptureEnable, CfgDataW'(1));
    write_reg(CfgFinalPeriod, CfgDataW'(first_stop));
    set_idling(IdleNone);
    offer_item(make_item(ActStart, 9'd0, '0));
    n       = 0;
    swapped = 1'b0;
    while (active_q) begin
      if (n % 512 == 0) set_idling(idle_mode_e'((n / 512) % 4));
      if (!swapped && swap_at != 0 && period_q == swap_at) begin
        settle();
        write_reg(CfgFinalPeriod, CfgDataW'(later_stop));
        swapped = 1'b1;
      end
      if ($urandom_range(9) == 0) offer_item(read_item());
      else offer_item(tick_item());
      n++;
    end
    // a finished capture stores nothing more
    repeat (6) begin
      offer_item(read_item());
      offer_item(tick_item());
    end
    offer_item(make_item(ActStop, 9'd0, '0));
  endtask

  // Random mixes of all actions under changing settings and idling
  task automatic test_random_mix();
    int unsigned pick;
    for (int chunk = 0; chunk < 4; chunk++) begin
      settle();
      write_reg(CfgCaptureEnable, CfgDataW'($urandom_range(3) != 0));
      case (chunk)
        0:       write_reg(CfgFinalPeriod, CfgDataW'(1));
        1:       write_reg(CfgFinalPeriod, CfgDataW'(15));
        default: write_reg(CfgFinalPeriod, CfgDataW'($urandom_range(15, 1)));
      endcase
      set_idling(idle_mode_e'(chunk));
      offer_item(make_item(ActStart, pick_row(), random_samples()));
      repeat (100) begin
        pick = $urandom_range(99);
        if (pick < 4) offer_item(make_item(ActStart, pick_row(), random_samples()));
        else if (pick < 9) offer_item(make_item(ActStop, pick_row(), random_samples()));
        else if (pick < 27) offer_item(read_item());
        else offer_item(tick_item());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_enable_gating();
    test_backpressure();
    test_fill_to_finish(4'd1, 4'd0, 4'd0);
    test_fill_to_finish(4'd3, 4'd0, 4'd0);
    test_random_mix();
    test_fill_to_finish(4'd15, 4'd4, 4'd2);
    settle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/adc_pkg.sv
rtl/adc_ram.sv
rtl/adc_ctrl.sv
rtl/adc_dpath.sv
rtl/adaptive_decimating_capture.sv
rtl/adc_checker.sv
sim/tb_top.sv
